/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication failed");

`else

`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/alsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package alsd_pkg;

   localparam int COST_W  = 16;
   localparam int BYTE_W  = 8;
   localparam int LINE_W  = 2;
   localparam int CSR_IW  = 3;
   localparam int STAGE_OW = 6;

   localparam logic [COST_W-1:0] COST_MAX = '1;

   // Line codes
   localparam logic [LINE_W-1:0] LINE_A   = 2'd0;
   localparam logic [LINE_W-1:0] LINE_B   = 2'd1;
   localparam logic [LINE_W-1:0] LINE_C   = 2'd2;
   localparam logic [LINE_W-1:0] LINE_BAD = 2'd3;

   // Register indexes
   localparam logic [CSR_IW-1:0] CSR_ENTRY_A = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_ENTRY_B = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_ENTRY_C = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_EXIT_A  = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_EXIT_B  = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_EXIT_C  = 3'd5;

   typedef struct packed {
      logic load;       // latch item, form the three candidate sums
      logic pick;       // take minimum, write cost and predecessor
      logic advance;    // stage complete, roll costs forward
      logic fin_sum;    // add exit costs
      logic fin_pick;   // choose best end line, start traceback
      logic emit;       // load output register, read predecessor
      logic step;       // follow predecessor one stage back
   } alsd_cmd_type;

   typedef struct packed {
      logic dest_bad;
      logic dest_is_c;
      logic final_hit;
      logic k_zero;
      logic out_free;
   } alsd_sts_type;

   function automatic logic [COST_W-1:0] sat_cost(input logic [COST_W+1:0] v);
      logic [COST_W-1:0] r;
      r = (v[COST_W+1:COST_W] != 2'b00) ? COST_MAX : v[COST_W-1:0];
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/assembly_line_schedule_dp.sv */
// Three-line assembly-line scheduler. An input beat is accepted, then the minimum is picked (skipped for a bad line).
// The final-stage beat then adds the exit sums and picks the end line before the first result;
// the first result beat is loaded into the output register once that register is free.
// Traceback then alternates emit and step states per result beat (registered predecessor-RAM read).
// Reset (synchronous, active high) clears configuration, costs, stage count and output valid;
// the predecessor RAM is not cleared, every entry read is written earlier in the run.
`timescale 1ns / 1ps
`default_nettype none

module assembly_line_schedule_dp #(
   parameter int MAX_STAGES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // item beat
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // prod_cost, move_from_a, move_from_b, move_from_c
   input  wire logic [1:0]  req_tuser,   // dest_line
   input  wire logic        req_tlast,   // final_stage
   // configuration writes
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [7:0]  csr_wdata,
   // result beat
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // stage_index, chosen_line, total_cost
   output logic             rsp_tlast    // path_end
);
   import alsd_pkg::*;

   alsd_cmd_type cmd;
   alsd_sts_type sts;

   // sequencer: item accept, stage roll, final pick, traceback walk
   alsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // cost registers, predecessor RAM and output register
   alsd_dp #(
      .MAX_STAGES (MAX_STAGES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* rtl/core/alsd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module alsd_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire alsd_pkg::alsd_sts_type sts,
   output alsd_pkg::alsd_cmd_type     cmd
);
   import alsd_pkg::*;

   `include "assert_macros.svh"

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PICK,
      ST_FIN_SUM,
      ST_FIN_PICK,
      ST_EMIT,
      ST_STEP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            state_in = ST_IDLE;
            if (!sts.dest_bad) begin
               cmd.pick = 1'b1;
               if (sts.dest_is_c && sts.final_hit) begin
                  state_in = ST_FIN_SUM;
               end else begin
                  cmd.advance = sts.dest_is_c;
               end
            end
         end
         ST_FIN_SUM: begin
            cmd.fin_sum = 1'b1;
            state_in    = ST_FIN_PICK;
         end
         ST_FIN_PICK: begin
            cmd.fin_pick = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = sts.k_zero ? ST_IDLE : ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            state_in = ST_EMIT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // output register never overwritten while a beat is pending
   `ASSERT_IMP(a_emit_free, clock, reset, cmd.emit, sts.out_free)
   // a traceback step is always followed by an emit attempt
   `ASSERT_NXT(a_step_emit, clock, reset, cmd.step, state_ff == ST_EMIT)
   // final pick leads straight into the traceback, never back to input
   `ASSERT_NXT(a_fin_trace, clock, reset, cmd.fin_pick, !req_tready)

endmodule

`default_nettype wire

/* rtl/core/alsd_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module alsd_dp #(
   parameter int MAX_STAGES = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire alsd_pkg::alsd_cmd_type cmd,
   output alsd_pkg::alsd_sts_type      sts,
   input  wire logic [31:0]            req_tdata,
   input  wire logic [1:0]             req_tuser,
   input  wire logic                   req_tlast,
   input  wire logic                   csr_we,
   input  wire logic [2:0]             csr_index,
   input  wire logic [7:0]             csr_wdata,
   input  wire logic                   rsp_tready,
   output logic                        rsp_tvalid,
   output logic [23:0]                 rsp_tdata,
   output logic                        rsp_tlast
);
   import alsd_pkg::*;

   localparam int SW    = $clog2(MAX_STAGES);
   localparam int DEPTH = MAX_STAGES * 3;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [SW-1:0] LAST_STAGE = SW'(MAX_STAGES - 1);

   // configuration
   logic [BYTE_W-1:0] entry_ff [3];
   logic [BYTE_W-1:0] exit_ff  [3];

   // cost state
   logic [COST_W-1:0] prior_ff [3];
   logic [COST_W-1:0] prior_in [3];
   logic [COST_W-1:0] cur_ff   [3];
   logic [COST_W-1:0] cur_in   [3];
   logic [SW-1:0]     stage_ff, stage_in;

   // item and sums
   logic [LINE_W-1:0] dest_ff;
   logic              fin_ff;
   logic [COST_W-1:0] sum_ff [3];
   logic [COST_W-1:0] sum_in [3];
   logic [COST_W-1:0] tot_ff [3];

   // traceback
   logic [LINE_W-1:0] line_ff;
   logic [COST_W-1:0] total_ff;
   logic [SW-1:0]     k_ff;

   // predecessor store
   logic [LINE_W-1:0] pred_mem [DEPTH];
   logic [LINE_W-1:0] rd_data_ff;
   logic [AW-1:0]     wr_addr, rd_addr;

   // output register
   logic                rsp_valid_ff;
   logic [STAGE_OW-1:0] out_k_ff;
   logic [LINE_W-1:0]   out_line_ff;
   logic [COST_W-1:0]   out_total_ff;
   logic                out_end_ff;

   // input fields
   logic [BYTE_W-1:0] prod;
   logic [BYTE_W-1:0] move [3];
   logic [BYTE_W-1:0] entry_sel;

   // minimum pickers
   logic [COST_W-1:0] best_cost, fin_cost;
   logic [LINE_W-1:0] best_line, fin_line;

   assign prod    = req_tdata[7:0];
   assign move[0] = req_tdata[15:8];
   assign move[1] = req_tdata[23:16];
   assign move[2] = req_tdata[31:24];

   always_comb begin
      unique case (req_tuser)
         LINE_A:  entry_sel = entry_ff[0];
         LINE_B:  entry_sel = entry_ff[1];
         LINE_C:  entry_sel = entry_ff[2];
         default: entry_sel = '0;
      endcase
   end

   // candidate sums; first stage uses the entry cost, others never win
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (stage_ff == '0) begin
            sum_in[i] = (i == 0)
               ? sat_cost(18'(entry_sel) + 18'(prod)) : COST_MAX;
         end else begin
            sum_in[i] = sat_cost(18'(prior_ff[i]) + 18'(move[i]) + 18'(prod));
         end
      end
   end

   // ties to the lower line
   always_comb begin
      best_cost = sum_ff[0];
      best_line = LINE_A;
      if (sum_ff[1] < best_cost) begin
         best_cost = sum_ff[1];
         best_line = LINE_B;
      end
      if (sum_ff[2] < best_cost) begin
         best_cost = sum_ff[2];
         best_line = LINE_C;
      end
      fin_cost = tot_ff[0];
      fin_line = LINE_A;
      if (tot_ff[1] < fin_cost) begin
         fin_cost = tot_ff[1];
         fin_line = LINE_B;
      end
      if (tot_ff[2] < fin_cost) begin
         fin_cost = tot_ff[2];
         fin_line = LINE_C;
      end
   end

   always_comb begin
      stage_in = stage_ff;
      for (int i = 0; i < 3; i++) begin
         cur_in[i]   = cur_ff[i];
         prior_in[i] = prior_ff[i];
         if (cmd.pick && dest_ff == LINE_W'(i)) begin
            cur_in[i] = best_cost;
         end
         if (cmd.advance) begin
            prior_in[i] = cur_in[i];
         end
         if (cmd.fin_pick) begin
            cur_in[i]   = '0;
            prior_in[i] = '0;
         end
      end
      if (cmd.advance) begin
         stage_in = stage_ff + 1'b1;
      end
      if (cmd.fin_pick) begin
         stage_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            entry_ff[i] <= '0;
            exit_ff[i]  <= '0;
            prior_ff[i] <= '0;
            cur_ff[i]   <= '0;
         end
         stage_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_ENTRY_A: entry_ff[0] <= csr_wdata;
               CSR_ENTRY_B: entry_ff[1] <= csr_wdata;
               CSR_ENTRY_C: entry_ff[2] <= csr_wdata;
               CSR_EXIT_A:  exit_ff[0]  <= csr_wdata;
               CSR_EXIT_B:  exit_ff[1]  <= csr_wdata;
               CSR_EXIT_C:  exit_ff[2]  <= csr_wdata;
               default: ;
            endcase
         end
         for (int i = 0; i < 3; i++) begin
            prior_ff[i] <= prior_in[i];
            cur_ff[i]   <= cur_in[i];
         end
         stage_ff <= stage_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dest_ff <= req_tuser;
         fin_ff  <= req_tlast;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= sum_in[i];
         end
      end
      if (cmd.fin_sum) begin
         for (int i = 0; i < 3; i++) begin
            tot_ff[i] <= sat_cost(18'(cur_ff[i]) + 18'(exit_ff[i]));
         end
      end
      if (cmd.fin_pick) begin
         line_ff  <= fin_line;
         total_ff <= fin_cost;
         k_ff     <= stage_ff;
      end
      if (cmd.step) begin
         line_ff <= rd_data_ff;
         k_ff    <= k_ff - 1'b1;
      end
      if (cmd.emit) begin
         out_k_ff     <= STAGE_OW'(k_ff);
         out_line_ff  <= line_ff;
         out_total_ff <= total_ff;
         out_end_ff   <= (k_ff == '0);
      end
   end

   assign wr_addr = AW'((AW'(stage_ff) << 1) + AW'(stage_ff) + AW'(dest_ff));
   assign rd_addr = AW'((AW'(k_ff) << 1) + AW'(k_ff) + AW'(line_ff));

   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         pred_mem[wr_addr] <= best_line;
      end
      if (cmd.emit) begin
         rd_data_ff <= pred_mem[rd_addr];
      end
   end

   assign sts.dest_bad  = (dest_ff == LINE_BAD);
   assign sts.dest_is_c = (dest_ff == LINE_C);
   assign sts.final_hit = fin_ff || (stage_ff == LAST_STAGE);
   assign sts.k_zero    = (k_ff == '0);
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_total_ff, out_line_ff, out_k_ff};
   assign rsp_tlast  = out_end_ff;

endmodule

`default_nettype wire
